// ===== rtl/core/dense_layer_sigmoid_core_defines.svh =====
// Assertion macros shared by the core's modules.
// Each expects clk and rst_n in scope.
`ifndef DENSE_LAYER_SIGMOID_CORE_DEFINES_SVH
`define DENSE_LAYER_SIGMOID_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DLS_ASSERT(lbl, prop, msg)

`define DLS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dls_pkg.sv =====
package dls_pkg;

  localparam int WORD_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 48;
  localparam int PRE_W    = 50;
  localparam int CFG_W    = 9;
  localparam int INDEX_W  = 8;

  // Q3.12 scaling of the bias into the Q6.24 sum, and round half up
  localparam int FRAC_BITS  = 12;
  localparam int ROUND_HALF = 2048;
  // Pre-activation saturates outside [-2^SAT_BIT, 2^SAT_BIT) in Q6.24
  localparam int SAT_BIT    = 27;

  localparam logic [CFG_W-1:0] NEURON_COUNT_RESET = 9'd200;
  localparam int COUNT_CAP = 256;

  typedef struct packed {
    logic signed [WORD_W-1:0] weight;
    logic signed [WORD_W-1:0] activation;
    logic signed [WORD_W-1:0] bias;
    logic                     last_term;
  } dls_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] neuron_index;
    logic [WORD_W-1:0]  neuron_value;
    logic               layer_end;
  } dls_out_t;

  // Rounded pre-activation of one finished neuron, before saturation
  typedef struct packed {
    logic                    valid;
    logic signed [PRE_W-1:0] pre;
  } dls_pre_t;

endpackage

// ===== rtl/core/dls_mac.sv =====
`include "dense_layer_sigmoid_core_defines.svh"

module dls_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dls_pkg::dls_in_t  in_data,
  input  logic              pre_ready,
  output dls_pkg::dls_pre_t pre
);
  import dls_pkg::*;

  logic                     s1_valid_r;
  dls_in_t                  s1_data_r;
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [WORD_W-1:0] s2_bias_r;
  logic                     s2_last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     pre_valid_r;
  logic signed [PRE_W-1:0]  pre_val_r;
  logic signed [PRE_W-1:0]  pre_nxt;
  logic signed [PROD_W-1:0] prod_nxt;

  logic pre_free;
  logic s2_free;
  logic s1_free;

  assign pre_free = !pre_valid_r || pre_ready;
  assign s2_free  = !s2_valid_r || pre_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  assign prod_nxt = s1_data_r.weight * s1_data_r.activation;

  // Wrap the running sum modulo 2^48; clear it once the row is finished
  always_comb begin
    acc_nxt = acc_r;
    if (s2_valid_r && pre_free) begin
      if (s2_last_r) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_r + ACC_W'(s2_prod_r);
      end
    end
  end

  assign pre_nxt = PRE_W'(acc_r) + PRE_W'(s2_prod_r)
                 + (PRE_W'(s2_bias_r) <<< FRAC_BITS) + PRE_W'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      pre_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      // Only a row's last term goes on to the activation stage
      if (pre_free) begin
        pre_valid_r <= s2_valid_r && s2_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s2_free && s1_valid_r) begin
      s2_prod_r <= prod_nxt;
      s2_bias_r <= s1_data_r.bias;
      s2_last_r <= s1_data_r.last_term;
    end
    if (pre_free && s2_valid_r && s2_last_r) begin
      pre_val_r <= pre_nxt;
    end
  end

  assign pre = '{valid: pre_valid_r, pre: pre_val_r};

  `DLS_ASSERT_NXT(a_acc_clear, s2_valid_r && s2_last_r && pre_free, acc_r == '0, "accumulator not cleared after last term")
  `DLS_ASSERT_NXT(a_pre_hold, pre_valid_r && !pre_ready, pre_valid_r && $stable(pre_val_r), "stalled pre-activation changed")

endmodule

// ===== rtl/core/dls_act.sv =====
`include "dense_layer_sigmoid_core_defines.svh"

module dls_act #(
  parameter int MAX_NEURONS     = 256,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dls_pkg::dls_pre_t               pre,
  output logic                            pre_ready,
  input  logic [dls_pkg::CFG_W-1:0]       neuron_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dls_pkg::dls_out_t               out_data
);
  import dls_pkg::*;

  localparam int IW     = $clog2(SIGMOID_ENTRIES);
  localparam int CW     = $clog2(MAX_NEURONS);
  localparam int EW     = $clog2(MAX_NEURONS + 1);
  localparam int CMP_W  = ((EW > CFG_W) ? EW : CFG_W) + 1;
  localparam int SCL_W  = WORD_W + IW + 1;
  localparam logic [63:0] ENTRIES_W = 64'(SIGMOID_ENTRIES);
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] X_OFFSET  = 64'd524288;

  typedef logic [WORD_W-1:0] rom_t [SIGMOID_ENTRIES];

  // Shift-subtract division, used only while the table is built
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    int b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at each segment midpoint over [-8, 8), e^-|x| from a cubic and 8 squarings
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] off;
    logic [63:0] t;
    logic [63:0] h;
    logic [63:0] h2;
    logic [63:0] h3;
    logic [63:0] y;
    logic [63:0] d;
    logic [63:0] s;
    logic        neg;
    int          k;
    int          i;
    for (k = 0; k < SIGMOID_ENTRIES; k++) begin
      off = (64'(2 * k + 1) * X_OFFSET) / ENTRIES_W;
      neg = off < X_OFFSET;
      t   = neg ? (X_OFFSET - off) : (off - X_OFFSET);
      h   = t << 6;
      h2  = (h * h) >> 30;
      h3  = (h2 * h) >> 30;
      y   = ONE_Q30 - h + (h2 >> 1) - h3 / 64'd6;
      for (i = 0; i < 8; i++) begin
        y = (y * y) >> 30;
      end
      d = ONE_Q30 + y;
      if (neg) begin
        s = udiv((y << 16) + (d >> 1), d);
      end else begin
        s = udiv((64'd1 << 46) + (d >> 1), d);
      end
      if (s > 64'd65535) begin
        s = 64'd65535;
      end
      rom[k] = s[WORD_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  logic                s4_valid_r;
  logic [IW-1:0]       s4_idx_r;
  logic [INDEX_W-1:0]  s4_index_r;
  logic                s4_end_r;
  logic                out_valid_r;
  dls_out_t            out_data_r;
  logic [CW-1:0]       counter_r;
  logic [CW-1:0]       counter_nxt;

  logic                out_free;
  logic                s4_free;
  logic                in_range;
  logic [WORD_W-1:0]   biased;
  logic [SCL_W-1:0]    scaled;
  logic [IW:0]         idx_raw;
  logic [IW:0]         idx_clamped;
  logic [CMP_W-1:0]    cnt_cfg;
  logic [CMP_W-1:0]    eff_count;
  logic [CMP_W-1:0]    cnt_inc;
  logic                end_nxt;
  logic [CW+7:0]       cnt_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign s4_free   = !s4_valid_r || out_free;
  assign pre_ready = s4_free;

  // Saturate to Q3.12 and convert to offset binary
  assign in_range = (pre.pre[PRE_W-1:SAT_BIT] == '0) || (pre.pre[PRE_W-1:SAT_BIT] == '1);

  always_comb begin
    if (in_range) begin
      biased = {~pre.pre[SAT_BIT], pre.pre[SAT_BIT-1:FRAC_BITS]};
    end else if (pre.pre[PRE_W-1]) begin
      biased = '0;
    end else begin
      biased = '1;
    end
  end

  assign scaled  = SCL_W'(biased) * SCL_W'(SIGMOID_ENTRIES);
  assign idx_raw = scaled[SCL_W-1:WORD_W];

  always_comb begin
    if (idx_raw >= (IW + 1)'(SIGMOID_ENTRIES)) begin
      idx_clamped = (IW + 1)'(SIGMOID_ENTRIES - 1);
    end else begin
      idx_clamped = idx_raw;
    end
  end

  // Zero counts as one; anything above the cap counts as MAX_NEURONS
  assign cnt_cfg = CMP_W'(neuron_count);

  always_comb begin
    if (cnt_cfg == '0) begin
      eff_count = CMP_W'(1);
    end else if (cnt_cfg > CMP_W'(COUNT_CAP) || cnt_cfg > CMP_W'(MAX_NEURONS)) begin
      eff_count = CMP_W'(MAX_NEURONS);
    end else begin
      eff_count = cnt_cfg;
    end
  end

  assign cnt_inc     = CMP_W'(counter_r) + CMP_W'(1);
  assign end_nxt     = cnt_inc >= eff_count;
  assign counter_nxt = end_nxt ? '0 : cnt_inc[CW-1:0];
  assign cnt_ext     = (CW + 8)'(counter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      counter_r   <= '0;
    end else begin
      if (s4_free) begin
        s4_valid_r <= pre.valid;
        if (pre.valid) begin
          counter_r <= counter_nxt;
        end
      end
      if (out_free) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free && pre.valid) begin
      s4_idx_r   <= idx_clamped[IW-1:0];
      s4_index_r <= cnt_ext[INDEX_W-1:0];
      s4_end_r   <= end_nxt;
    end
    if (out_free && s4_valid_r) begin
      out_data_r <= '{neuron_index: s4_index_r,
                      neuron_value: SIG_ROM[s4_idx_r],
                      layer_end:    s4_end_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DLS_ASSERT_NXT(a_cnt_wrap, pre.valid && s4_free && end_nxt, counter_r == '0, "neuron counter did not wrap at layer end")
  `DLS_ASSERT(a_cnt_range, counter_r <= CW'(MAX_NEURONS - 1), "neuron counter out of range")

endmodule

// ===== rtl/core/dense_layer_sigmoid_core.sv =====
// A row's last term goes through the s1, s2, pre, s4 and out registers to
// out_valid. Throughput: one weight/activation term per cycle unless out_ready
// stalls; the multiply, the accumulate loop and the table read each own a stage.
// Terms other than a row's last produce no result and leave the pipe early.
// Reset (rst_n low, synchronous) empties the pipe, clears accumulator and
// neuron counter, and sets neuron_count to 200; the sigmoid table is constant.
module dense_layer_sigmoid_core #(
  parameter int MAX_NEURONS     = 256,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dls_pkg::dls_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dls_pkg::dls_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [dls_pkg::CFG_W-1:0] cfg_wr_data
);
  import dls_pkg::*;

  logic [CFG_W-1:0] neuron_count_r;
  dls_pre_t         pre;
  logic             pre_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neuron_count_r <= NEURON_COUNT_RESET;
    end else if (cfg_wr_en) begin
      neuron_count_r <= cfg_wr_data;
    end
  end

  dls_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pre_ready (pre_ready),
    .pre       (pre)
  );

  dls_act #(
    .MAX_NEURONS     (MAX_NEURONS),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_act (
    .clk          (clk),
    .rst_n        (rst_n),
    .pre          (pre),
    .pre_ready    (pre_ready),
    .neuron_count (neuron_count_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ===== test/dense_layer_sigmoid_checker.sv =====
`timescale 1ns / 100ps

module dense_layer_sigmoid_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  dls_pkg::dls_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  dls_pkg::dls_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data,
  output int                fail_count,
  output int                neurons_due,
  output int                neurons_checked,
  output int                layers_closed
);
  import dls_pkg::*;

  localparam int SIG_ENTRIES = 256;
  localparam int NEURON_CAP = 256;
  localparam logic [8:0] RESET_NEURON_COUNT = 9'd200;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint SAT_SPAN = 64'sd134217728;

  logic [15:0]        sigmoid_lut [SIG_ENTRIES];
  logic signed [47:0] acc_q;
  int unsigned        neuron_ctr;
  logic [8:0]         count_q;
  dls_out_t           due_neurons [$];

  initial begin
    fail_count = 0;
    neurons_due = 0;
    neurons_checked = 0;
    layers_closed = 0;
  end

  // Sigmoid at the segment midpoint: e^-t from a cubic of t/256 squared 8 times.
  function automatic logic [15:0] sigmoid_entry(int k);
    longint x;
    longint unsigned t, h, h2, h3, y, d, s;
    x = (longint'(2 * k + 1) * 524288) / SIG_ENTRIES - 524288;
    t = (x < 0) ? -x : x;
    h = t << 6;
    h2 = (h * h) >> 30;
    h3 = (h2 * h) >> 30;
    y = ONE_Q30 - h + (h2 >> 1) - h3 / 64'd6;
    repeat (8) y = (y * y) >> 30;
    d = ONE_Q30 + y;
    if (x >= 0) s = ((64'd1 << 46) + d / 64'd2) / d;
    else s = ((y << 16) + d / 64'd2) / d;
    if (s > 64'd65535) s = 64'd65535;
    return s[15:0];
  endfunction

  initial begin
    for (int k = 0; k < SIG_ENTRIES; k++) sigmoid_lut[k] = sigmoid_entry(k);
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic accumulate_term(dls_in_t term);
    longint prod, total, xr, biased, idx;
    int unsigned n;
    logic at_end;
    dls_out_t res;
    prod = longint'($signed(term.weight)) * longint'($signed(term.activation));
    if (!term.last_term) begin
      acc_q = 48'(acc_q + prod);
    end else begin
      total = longint'(acc_q) + prod + longint'($signed(term.bias)) * 4096;
      xr = total + 2048;
      if (xr >= SAT_SPAN) biased = 65535;
      else if (xr < -SAT_SPAN) biased = 0;
      else biased = (xr + SAT_SPAN) >>> 12;
      idx = (biased * SIG_ENTRIES) >>> 16;
      if (idx >= SIG_ENTRIES) idx = SIG_ENTRIES - 1;
      n = 32'(count_q);
      if (n == 0) n = 1;
      if (n > NEURON_CAP) n = NEURON_CAP;
      at_end = (neuron_ctr + 1 >= n);
      res.neuron_index = neuron_ctr[7:0];
      res.neuron_value = sigmoid_lut[idx];
      res.layer_end = at_end;
      due_neurons.push_back(res);
      acc_q = '0;
      neuron_ctr = at_end ? 0 : neuron_ctr + 1;
    end
  endtask

  task automatic check_neuron(dls_out_t got);
    dls_out_t want;
    if (due_neurons.size() == 0) begin
      report_mismatch($sformatf("result index %0d value %0h with no neuron pending",
                                got.neuron_index, got.neuron_value));
    end else begin
      want = due_neurons.pop_front();
      neurons_checked++;
      if (want.layer_end) layers_closed++;
      if (got.neuron_index !== want.neuron_index)
        report_mismatch($sformatf("neuron_index %0d, want %0d",
                                  got.neuron_index, want.neuron_index));
      if (got.neuron_value !== want.neuron_value)
        report_mismatch($sformatf("neuron %0d value %0h, want %0h",
                                  want.neuron_index, got.neuron_value, want.neuron_value));
      if (got.layer_end !== want.layer_end)
        report_mismatch($sformatf("neuron %0d layer_end %0b, want %0b",
                                  want.neuron_index, got.layer_end, want.layer_end));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_q = '0;
      neuron_ctr = 0;
      count_q = RESET_NEURON_COUNT;
      due_neurons.delete();
    end else begin
      if (cfg_wr_en) count_q = cfg_wr_data;
      // Match the result against earlier transactions before queuing this edge's term
      if (out_valid && out_ready) check_neuron(out_data);
      if (in_valid && in_ready) accumulate_term(in_data);
    end
    neurons_due <= due_neurons.size();
  end

endmodule

// ===== test/tb_dense_layer_sigmoid_core.sv =====
`timescale 1ns / 100ps

module tb_dense_layer_sigmoid_core;
  import dls_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  // Row of the largest product, long enough to push the sum far past the Q3.12 range
  localparam int LONG_ROW_TERMS = 48;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  dls_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  dls_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;

  int fail_count, neurons_due, neurons_checked, layers_closed;
  int idle_pct = 0;
  int stall_pct = 0;
  int terms_sent = 0;
  int settings_used = 1;
  int cycles = 0;

  always #1 clk = ~clk;

  dense_layer_sigmoid_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dense_layer_sigmoid_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .neurons_due    (neurons_due),
    .neurons_checked(neurons_checked),
    .layers_closed  (layers_closed)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d neurons still pending", cycles, neurons_due);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_term(logic signed [15:0] w, logic signed [15:0] a,
                           logic signed [15:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{weight: w, activation: a, bias: b, last_term: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    terms_sent++;
  endtask

  // Hold the sender until every pending neuron has come out and the pipe is quiet.
  task automatic drain_neurons();
    in_valid <= 1'b0;
    do @(posedge clk); while (neurons_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_neuron_count(logic [8:0] value);
    drain_neurons();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [15:0] pick_word(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(8191) - 4096);
      2: begin
        case ($urandom_range(3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom_range(2047) - 1024);
    endcase
  endfunction

  task automatic send_row();
    int len, wmode, bmode;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    wmode = $urandom_range(3);
    bmode = $urandom_range(3);
    for (int i = 0; i < len; i++)
      send_term(pick_word(wmode), pick_word(wmode), pick_word(bmode), i == len - 1);
  endtask

  task automatic run_rows(int idle, int stall, int term_budget);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = terms_sent + term_budget;
    while (terms_sent < stop_at) begin
      send_row();
      if ($urandom_range(39) == 0) drain_neurons();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-term rows: saturation both ways, rounding at the half step, bias extremes
    send_term(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_term(16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
    send_term(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_term(16'sd1, 16'sd2048, 16'sd0, 1'b1);
    send_term(-16'sd1, 16'sd2048, 16'sd0, 1'b1);
    send_term(-16'sd1, 16'sd2049, 16'sd0, 1'b1);
    send_term(16'sd0, 16'sd0, -16'sd32768, 1'b1);
    send_term(16'sd0, 16'sd0, 16'sd32767, 1'b1);
    send_term(16'sd2047, 16'sd1, 16'sd32767, 1'b1);
    send_term(16'sd2048, 16'sd1, 16'sd32767, 1'b1);
    send_term(-16'sd1, -16'sd1, -16'sd1, 1'b1);
    // Multi-term rows: cancel to zero, a large positive sum, then a small negative sum
    send_term(16'sd4096, 16'sd4096, 16'sd0, 1'b0);
    send_term(16'sd4096, 16'sd4096, 16'sd0, 1'b0);
    send_term(-16'sd4096, 16'sd4096, -16'sd4096, 1'b1);
    send_term(16'sd32767, 16'sd32767, 16'sd0, 1'b0);
    send_term(16'sd32767, 16'sd32767, -16'sd1, 1'b1);
    send_term(16'sd1024, -16'sd3000, 16'sd0, 1'b0);
    send_term(-16'sd700, 16'sd900, 16'sd512, 1'b1);

    // Long row of the largest product: the sum saturates high
    for (int i = 0; i < LONG_ROW_TERMS; i++)
      send_term(-16'sd32768, -16'sd32768, 16'sd0, 1'b0);
    send_term(16'sd0, 16'sd0, 16'sd0, 1'b1);

    run_rows(0, 0, 300);
    write_neuron_count(9'd1);
    run_rows(49, 0, 250);
    write_neuron_count(9'd256);
    run_rows(0, 49, 300);
    write_neuron_count(9'd0);
    run_rows(35, 35, 200);
    write_neuron_count(9'd511);
    run_rows(0, 0, 150);
    write_neuron_count(9'd2);
    run_rows(49, 0, 150);
    write_neuron_count(9'd7);
    run_rows(35, 35, 100);

    drain_neurons();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d terms over %0d neuron count settings under mixed idle and stall.",
             terms_sent, settings_used);
    $display("Checked %0d neuron results, %0d of them closing a layer.",
             neurons_checked, layers_closed);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
